/* design/ordf_pkg.sv */
// Shared types, codes and the record-type decoder for the object record deframer.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package ordf_pkg;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1052;

  // Record framing phase, one-hot
  typedef enum logic [4:0] {
    PH_TYPE    = 5'b00001,
    PH_LENLO   = 5'b00010,
    PH_LENHI   = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_SUM     = 5'b10000
  } phase_t;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [2:0] ROLE_TYPE    = 3'd0;
  localparam logic [2:0] ROLE_LENLO   = 3'd1;
  localparam logic [2:0] ROLE_LENHI   = 3'd2;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
  localparam logic [2:0] ROLE_SUM     = 3'd4;
  localparam logic [2:0] ROLE_NONE    = 3'd5;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_PREMATURE  = 3'd1;
  localparam logic [2:0] ST_ZERO_LEN   = 3'd2;
  localparam logic [2:0] ST_OVERLONG   = 3'd3;
  localparam logic [2:0] ST_BAD_SUM    = 3'd4;
  localparam logic [2:0] ST_UNKNOWN    = 3'd5;
  localparam logic [2:0] ST_HALTED     = 3'd6;
  localparam logic [2:0] ST_CLEAN_END  = 3'd7;

  localparam logic [3:0] CLASS_UNKNOWN = 4'd13;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [2:0]  role;
    logic [7:0]  value;
    logic [31:0] offset;
    logic [15:0] position;
    logic [15:0] length;
    logic [31:0] start;
    logic [15:0] index;
    logic        done;
    logic [3:0]  rec_class;
    logic [2:0]  status;
  } result_t;

  // Map a record type byte onto its class number
  function automatic logic [3:0] classify(input logic [7:0] t);
    logic [3:0] c;
    unique case (t)
      8'h80:   c = 4'd0;
      8'h88:   c = 4'd1;
      8'h8A:   c = 4'd2;
      8'h8C:   c = 4'd3;
      8'h8E:   c = 4'd4;
      8'h90:   c = 4'd5;
      8'h94:   c = 4'd6;
      8'h96:   c = 4'd7;
      8'h98:   c = 4'd8;
      8'h9A:   c = 4'd9;
      8'h9C:   c = 4'd10;
      8'hA0:   c = 4'd11;
      8'hA2:   c = 4'd12;
      default: c = CLASS_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

/* design/ordf_in_stage.sv */
// Input register for the object record deframer: holds one item until the core takes it.
// Depends on ordf_pkg.
`timescale 1ns / 1ps

module ordf_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_stall,
  input  logic          cmd,
  input  logic [7:0]    data_byte,
  input  logic          advance,
  output logic          item_valid,
  output ordf_pkg::item_t item
);

  // hold while an item sits here and the core cannot take it
  assign byte_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!byte_stall) begin
      item_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      item.cmd  <= cmd;
      item.data <= data_byte;
    end
  end

endmodule

/* design/ordf_core.sv */
// Framing state and per-item result logic of the object record deframer.
// Holds phase, counters, running sum and the payload limit register. Depends on ordf_pkg.
`timescale 1ns / 1ps

module ordf_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_data,
  input  logic              advance,
  input  ordf_pkg::item_t   item,
  output ordf_pkg::result_t result
);

  ordf_pkg::phase_t phase, phase_next;
  logic [7:0]  type_byte, type_byte_next;
  logic [15:0] length_value, length_value_next;
  logic [15:0] payload_count, payload_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [31:0] file_offset, file_offset_next;
  logic [31:0] start_offset, start_offset_next;
  logic [15:0] record_counter, record_counter_next;
  logic        halted, halted_next;
  logic [15:0] max_payload;

  always_comb begin
    phase_next          = phase;
    type_byte_next      = type_byte;
    length_value_next   = length_value;
    payload_count_next  = payload_count;
    running_sum_next    = running_sum;
    file_offset_next    = file_offset;
    start_offset_next   = start_offset;
    halted_next         = halted;

    result.role      = ordf_pkg::ROLE_NONE;
    result.value     = (item.cmd == ordf_pkg::CMD_DATA) ? item.data : 8'd0;
    result.offset    = file_offset;
    result.position  = 16'd0;
    result.done      = 1'b0;
    result.rec_class = 4'd0;
    result.status    = ordf_pkg::ST_OK;

    if (halted) begin
      result.status = ordf_pkg::ST_HALTED;
    end else if (item.cmd == ordf_pkg::CMD_END) begin
      if (phase == ordf_pkg::PH_TYPE) begin
        result.status = ordf_pkg::ST_CLEAN_END;
      end else begin
        result.status = ordf_pkg::ST_PREMATURE;
        halted_next   = 1'b1;
      end
    end else begin
      file_offset_next = file_offset + 32'd1;
      running_sum_next = running_sum + item.data;
      unique case (phase)
        ordf_pkg::PH_TYPE: begin
          result.role        = ordf_pkg::ROLE_TYPE;
          type_byte_next     = item.data;
          running_sum_next   = item.data;
          start_offset_next  = file_offset;
          length_value_next  = 16'd0;
          payload_count_next = 16'd0;
          phase_next         = ordf_pkg::PH_LENLO;
        end
        ordf_pkg::PH_LENLO: begin
          result.role       = ordf_pkg::ROLE_LENLO;
          length_value_next = {8'd0, item.data};
          phase_next        = ordf_pkg::PH_LENHI;
        end
        ordf_pkg::PH_LENHI: begin
          result.role       = ordf_pkg::ROLE_LENHI;
          length_value_next = {item.data, length_value[7:0]};
          if (length_value_next == 16'd0) begin
            result.status = ordf_pkg::ST_ZERO_LEN;
            halted_next   = 1'b1;
          end else if ((length_value_next - 16'd1) > max_payload) begin
            result.status = ordf_pkg::ST_OVERLONG;
            halted_next   = 1'b1;
          end else if (length_value_next == 16'd1) begin
            phase_next = ordf_pkg::PH_SUM;
          end else begin
            phase_next = ordf_pkg::PH_PAYLOAD;
          end
        end
        ordf_pkg::PH_PAYLOAD: begin
          result.role        = ordf_pkg::ROLE_PAYLOAD;
          result.position    = payload_count;
          payload_count_next = payload_count + 16'd1;
          if (payload_count_next >= (length_value - 16'd1)) begin
            phase_next = ordf_pkg::PH_SUM;
          end
        end
        ordf_pkg::PH_SUM: begin
          result.role      = ordf_pkg::ROLE_SUM;
          result.rec_class = ordf_pkg::classify(type_byte);
          if (running_sum_next != 8'd0) begin
            result.status = ordf_pkg::ST_BAD_SUM;
            halted_next   = 1'b1;
          end else if (result.rec_class == ordf_pkg::CLASS_UNKNOWN) begin
            result.status = ordf_pkg::ST_UNKNOWN;
            halted_next   = 1'b1;
          end else begin
            result.done = 1'b1;
          end
          phase_next = ordf_pkg::PH_TYPE;
        end
        default: begin
          phase_next = ordf_pkg::PH_TYPE;
        end
      endcase
    end

    result.length = length_value_next;
    result.start  = start_offset_next;
    result.index  = record_counter;
    record_counter_next = result.done ? (record_counter + 16'd1) : record_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ordf_pkg::PH_TYPE;
      type_byte      <= 8'd0;
      length_value   <= 16'd0;
      payload_count  <= 16'd0;
      running_sum    <= 8'd0;
      file_offset    <= 32'd0;
      start_offset   <= 32'd0;
      record_counter <= 16'd0;
      halted         <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      type_byte      <= type_byte_next;
      length_value   <= length_value_next;
      payload_count  <= payload_count_next;
      running_sum    <= running_sum_next;
      file_offset    <= file_offset_next;
      start_offset   <= start_offset_next;
      record_counter <= record_counter_next;
      halted         <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= ordf_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      max_payload <= cfg_data;
    end
  end

endmodule

/* design/ordf_out_stage.sv */
// Result register for the object record deframer: holds a result until the sink takes it.
// Depends on ordf_pkg.
`timescale 1ns / 1ps

module ordf_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  ordf_pkg::result_t result_in,
  output logic              advance,
  output logic              result_valid,
  input  logic              result_stall,
  output ordf_pkg::result_t result
);

  // take a new result whenever the register is empty or being drained
  assign advance = item_valid && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_in;
    end
  end

endmodule

/* design/object_record_deframer.sv */
// Object record deframer: tags each byte of an object-file stream with its record role.
// An accepted item sits in one input register, then its result in one result register.
// Throughput: one item per cycle unless the sink stalls.
// Reset (rst, synchronous): expect a type byte, counters and offsets zero, not halted,
// payload limit back to 1052. An error halts the block until the next reset.
`timescale 1ns / 1ps

module object_record_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic        cmd,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  byte_role,
  output logic [7:0]  byte_value,
  output logic [31:0] byte_offset,
  output logic [15:0] payload_position,
  output logic [15:0] record_length,
  output logic [31:0] record_start,
  output logic [15:0] record_index,
  output logic        record_done,
  output logic [3:0]  record_class,
  output logic [2:0]  status
);

  logic              advance;
  logic              item_valid;
  ordf_pkg::item_t   item;
  ordf_pkg::result_t core_result;
  ordf_pkg::result_t result;

  ordf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .cmd        (cmd),
    .data_byte  (data_byte),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ordf_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .advance  (advance),
    .item     (item),
    .result   (core_result)
  );

  ordf_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .result_in    (core_result),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign byte_role        = result.role;
  assign byte_value       = result.value;
  assign byte_offset      = result.offset;
  assign payload_position = result.position;
  assign record_length    = result.length;
  assign record_start     = result.start;
  assign record_index     = result.index;
  assign record_done      = result.done;
  assign record_class     = result.rec_class;
  assign status           = result.status;

endmodule

/* design/ordf_checker.sv */
// Port-level checks for the object record deframer, bound to the top level.
// Depends on ordf_pkg and object_record_deframer.
`timescale 1ns / 1ps

module ordf_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic [2:0]  byte_role,
  input logic [31:0] byte_offset,
  input logic [15:0] payload_position,
  input logic [15:0] record_length,
  input logic [31:0] record_start,
  input logic        record_done,
  input logic [3:0]  record_class,
  input logic [2:0]  status
);

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(byte_offset)
      && $stable(byte_role) && $stable(status))
    else $error("stalled result changed");

  // a completed record is a clean checksum byte of a known type
  a_done_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && record_done |-> byte_role == ordf_pkg::ROLE_SUM
      && status == ordf_pkg::ST_OK && record_class != ordf_pkg::CLASS_UNKNOWN)
    else $error("record done on a bad record");

  // only payload bytes carry a position
  a_position: assert property (@(posedge clk) disable iff (rst)
    result_valid && byte_role != ordf_pkg::ROLE_PAYLOAD |-> payload_position == 16'd0)
    else $error("position on a non-payload byte");

  // a type byte opens the record at its own offset
  a_type_start: assert property (@(posedge clk) disable iff (rst)
    result_valid && byte_role == ordf_pkg::ROLE_TYPE |->
      record_start == byte_offset && record_length == 16'd0)
    else $error("type byte does not open the record");

endmodule

bind object_record_deframer ordf_checker u_ordf_checker (
  .clk              (clk),
  .rst              (rst),
  .result_valid     (result_valid),
  .result_stall     (result_stall),
  .byte_role        (byte_role),
  .byte_offset      (byte_offset),
  .payload_position (payload_position),
  .record_length    (record_length),
  .record_start     (record_start),
  .record_done      (record_done),
  .record_class     (record_class),
  .status           (status)
);

/* verif/tb.sv */
// Self-checking bench for object_record_deframer: random and directed record streams.
// Depends on ordf_pkg and object_record_deframer; drives, predicts and checks every item.
`timescale 1ns / 1ps

module tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam logic [12:0][7:0] KNOWN_TYPES = {
    8'hA2, 8'hA0, 8'h9C, 8'h9A, 8'h98, 8'h96, 8'h94,
    8'h90, 8'h8E, 8'h8C, 8'h8A, 8'h88, 8'h80
  };

  typedef enum int {BRK_PREMATURE, BRK_ZERO_LEN, BRK_OVERLONG, BRK_BAD_SUM, BRK_UNKNOWN} break_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic        cmd = ordf_pkg::CMD_DATA;
  logic [7:0]  data_byte = 8'd0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  byte_role;
  logic [7:0]  byte_value;
  logic [31:0] byte_offset;
  logic [15:0] payload_position;
  logic [15:0] record_length;
  logic [31:0] record_start;
  logic [15:0] record_index;
  logic        record_done;
  logic [3:0]  record_class;
  logic [2:0]  status;

  object_record_deframer uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .byte_valid(byte_valid), .byte_stall(byte_stall),
    .cmd(cmd), .data_byte(data_byte),
    .result_valid(result_valid), .result_stall(result_stall),
    .byte_role(byte_role), .byte_value(byte_value), .byte_offset(byte_offset),
    .payload_position(payload_position), .record_length(record_length),
    .record_start(record_start), .record_index(record_index),
    .record_done(record_done), .record_class(record_class), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ordf_pkg::item_t   stream_bytes[$];
  ordf_pkg::result_t predicted_tags[$];
  ordf_pkg::item_t   held;
  ordf_pkg::result_t want;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      gap_pct = 0;
  int      stall_pct = 0;
  int      hold_left = 0;
  bit      hold_off_req = 1'b0;

  // Deframer state as the bench sees it
  ordf_pkg::phase_t ph = ordf_pkg::PH_TYPE;
  logic [7:0]  rec_type = 8'd0;
  logic [15:0] rec_len = 16'd0;
  logic [15:0] pay_cnt = 16'd0;
  logic [7:0]  run_sum = 8'd0;
  logic [31:0] file_pos = 32'd0;
  logic [31:0] rec_first = 32'd0;
  logic [15:0] rec_count = 16'd0;
  logic        stopped = 1'b0;
  logic [15:0] payload_limit = ordf_pkg::MAX_PAYLOAD_RESET;

  function automatic logic [3:0] type_class(input logic [7:0] t);
    for (int k = 0; k < 13; k++)
      if (KNOWN_TYPES[4'(k)] == t) return 4'(k);
    return ordf_pkg::CLASS_UNKNOWN;
  endfunction

  function automatic logic [7:0] random_type();
    logic [3:0] k;
    k = 4'($urandom_range(0, 12));
    return KNOWN_TYPES[k];
  endfunction

  // Advance the framing state by one item and return the tag it earns
  function automatic ordf_pkg::result_t frame_byte(input ordf_pkg::item_t it);
    ordf_pkg::result_t r;
    r = '0;
    r.role = ordf_pkg::ROLE_NONE;
    r.status = ordf_pkg::ST_OK;
    r.offset = file_pos;
    r.value = (it.cmd == ordf_pkg::CMD_DATA) ? it.data : 8'h00;
    if (stopped) begin
      r.status = ordf_pkg::ST_HALTED;
    end else if (it.cmd == ordf_pkg::CMD_END) begin
      if (ph == ordf_pkg::PH_TYPE) begin
        r.status = ordf_pkg::ST_CLEAN_END;
      end else begin
        r.status = ordf_pkg::ST_PREMATURE;
        stopped = 1'b1;
      end
    end else begin
      file_pos = file_pos + 32'd1;
      run_sum = run_sum + it.data;
      case (ph)
        ordf_pkg::PH_TYPE: begin
          r.role = ordf_pkg::ROLE_TYPE;
          rec_type = it.data;
          run_sum = it.data;
          rec_first = r.offset;
          rec_len = 16'd0;
          pay_cnt = 16'd0;
          ph = ordf_pkg::PH_LENLO;
        end
        ordf_pkg::PH_LENLO: begin
          r.role = ordf_pkg::ROLE_LENLO;
          rec_len = {8'h00, it.data};
          ph = ordf_pkg::PH_LENHI;
        end
        ordf_pkg::PH_LENHI: begin
          r.role = ordf_pkg::ROLE_LENHI;
          rec_len = {it.data, rec_len[7:0]};
          if (rec_len == 16'd0) begin
            r.status = ordf_pkg::ST_ZERO_LEN;
            stopped = 1'b1;
          end else if (rec_len - 16'd1 > payload_limit) begin
            r.status = ordf_pkg::ST_OVERLONG;
            stopped = 1'b1;
          end else begin
            ph = (rec_len == 16'd1) ? ordf_pkg::PH_SUM : ordf_pkg::PH_PAYLOAD;
          end
        end
        ordf_pkg::PH_PAYLOAD: begin
          r.role = ordf_pkg::ROLE_PAYLOAD;
          r.position = pay_cnt;
          pay_cnt = pay_cnt + 16'd1;
          if (pay_cnt >= rec_len - 16'd1) ph = ordf_pkg::PH_SUM;
        end
        default: begin
          r.role = ordf_pkg::ROLE_SUM;
          r.rec_class = type_class(rec_type);
          if (run_sum != 8'd0) begin
            r.status = ordf_pkg::ST_BAD_SUM;
            stopped = 1'b1;
          end else if (r.rec_class == ordf_pkg::CLASS_UNKNOWN) begin
            r.status = ordf_pkg::ST_UNKNOWN;
            stopped = 1'b1;
          end else begin
            r.done = 1'b1;
          end
          ph = ordf_pkg::PH_TYPE;
        end
      endcase
    end
    r.length = rec_len;
    r.start = rec_first;
    r.index = rec_count;
    if (r.done) rec_count = rec_count + 16'd1;
    return r;
  endfunction

  // Offer items from the backlog; hold a stalled item
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) predicted_tags.push_back(frame_byte(held));
      if (!byte_valid || !byte_stall) begin
        if (stream_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
          held = stream_bytes.pop_front();
          byte_valid <= 1'b1;
          cmd <= held.cmd;
          data_byte <= held.data;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (predicted_tags.size() == 0) begin
          $error("unexpected result: role %0d offset %0d", byte_role, byte_offset);
          mismatches++;
        end else begin
          want = predicted_tags.pop_front();
          check_field("byte_role", 32'(want.role), 32'(byte_role));
          check_field("byte_value", 32'(want.value), 32'(byte_value));
          check_field("byte_offset", want.offset, byte_offset);
          check_field("payload_position", 32'(want.position), 32'(payload_position));
          check_field("record_length", 32'(want.length), 32'(record_length));
          check_field("record_start", want.start, record_start);
          check_field("record_index", 32'(want.index), 32'(record_index));
          check_field("record_done", 32'(want.done), 32'(record_done));
          check_field("record_class", 32'(want.rec_class), 32'(record_class));
          check_field("status", 32'(want.status), 32'(status));
        end
      end
      if (hold_off_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      result_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
      if (hold_left > 0) hold_left = hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic put_byte(input logic [7:0] b);
    stream_bytes.push_back(ordf_pkg::item_t'{ordf_pkg::CMD_DATA, b});
  endtask

  task automatic put_end();
    stream_bytes.push_back(ordf_pkg::item_t'{ordf_pkg::CMD_END, 8'($urandom)});
  endtask

  // Queue a whole record; a non-zero skew spoils the checksum
  task automatic queue_record(input logic [7:0] rtype, input int len, input logic [7:0] skew);
    logic [7:0] acc;
    logic [7:0] p;
    logic [15:0] l16;
    l16 = 16'(len);
    acc = rtype + l16[7:0] + l16[15:8];
    put_byte(rtype);
    put_byte(l16[7:0]);
    put_byte(l16[15:8]);
    for (int i = 1; i < len; i++) begin
      p = 8'($urandom);
      acc = acc + p;
      put_byte(p);
    end
    put_byte(8'h00 - acc + skew);
  endtask

  // Well-formed records of known types, the odd end mark between them
  task automatic queue_stream(input int n_items);
    int lim;
    int hi;
    int len;
    int queued;
    lim = int'(payload_limit) + 1;
    hi = (lim < 24) ? lim : 24;
    queued = 0;
    while (queued < n_items) begin
      if ($urandom_range(99) < 6) begin
        put_end();
        queued++;
      end else begin
        if (lim >= 600 && $urandom_range(99) < 3) len = $urandom_range(256, 600);
        else len = $urandom_range(1, hi);
        queue_record(random_type(), len, 8'h00);
        queued += len + 3;
      end
    end
  endtask

  task automatic set_payload_limit(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    payload_limit = v;
  endtask

  task automatic wait_idle();
    while (stream_bytes.size() != 0 || byte_valid || predicted_tags.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    break_t kind;
    int cut;
    logic [7:0] t;
    logic [16:0] over;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: end mark at offset zero, length one, end between records
    put_end();
    queue_record(8'h80, 1, 8'h00);
    stream_bytes.push_back(ordf_pkg::item_t'{ordf_pkg::CMD_DATA, 8'h00});
    stream_bytes.pop_back();
    queue_record(8'hA2, 3, 8'h00);
    put_end();
    queue_record(8'h88, 2, 8'h00);
    put_byte(8'hFF);
    stream_bytes.pop_back();
    put_end();
    wait_idle();

    set_payload_limit(16'hFFFF);
    gap_pct = 52;
    queue_stream(300);
    wait_idle();

    // Payload limit of one; long receiver hold-off while the sender keeps offering
    set_payload_limit(16'd1);
    gap_pct = 0;
    stall_pct = 52;
    queue_stream(260);
    hold_off_req = 1'b1;
    wait_idle();

    set_payload_limit(16'($urandom_range(2, 20)));
    gap_pct = 34;
    stall_pct = 34;
    queue_stream(340);
    wait_idle();

    set_payload_limit(16'($urandom_range(2, 65533)));
    gap_pct = 0;
    stall_pct = 0;
    queue_stream(330);
    wait_idle();

    // One halting error per run, then items that must be refused as halted
    gap_pct = 34;
    stall_pct = 34;
    kind = break_t'($urandom_range(0, 4));
    case (kind)
      BRK_PREMATURE: begin
        cut = $urandom_range(1, 4);
        put_byte(random_type());
        if (cut > 1) put_byte(8'h03);
        if (cut > 2) put_byte(8'h00);
        if (cut > 3) put_byte(8'($urandom));
        put_end();
      end
      BRK_ZERO_LEN: begin
        put_byte(random_type());
        put_byte(8'h00);
        put_byte(8'h00);
      end
      BRK_OVERLONG: begin
        over = 17'(payload_limit) + 17'd2;
        put_byte(random_type());
        put_byte(over[7:0]);
        put_byte(over[15:8]);
      end
      BRK_BAD_SUM: begin
        queue_record(random_type(), $urandom_range(1, 6),
                     8'($urandom_range(1, 255)));
      end
      default: begin
        do t = 8'($urandom); while (type_class(t) != ordf_pkg::CLASS_UNKNOWN);
        queue_record(t, $urandom_range(1, 6), 8'h00);
      end
    endcase
    for (int i = 0; i < 12; i++) begin
      if ($urandom_range(1)) put_end();
      else put_byte(8'($urandom));
    end
    wait_idle();
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
design/ordf_pkg.sv
design/ordf_in_stage.sv
design/ordf_core.sv
design/ordf_out_stage.sv
design/object_record_deframer.sv
design/ordf_checker.sv
verif/tb.sv
